/* src/xcfd_pkg.sv */
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the XOR-checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h4A;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] function_code;
    logic [15:0] frame_length;
    logic [15:0] byte_index;
  } result_t;

endpackage

/* src/xor_checked_frame_deframer.sv */
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Byte-serial deframer: header 0x4A, 16-bit code, 16-bit length, payload,
// XOR checksum seeded with 0x4A. Emits payload bytes and a frame verdict.
// ----------------------------------------------------------------------------
// Path: a byte transfer lands in the input register, and the parser feeds its
// result into the result register once the skid entry is free.
// Throughput: one byte per cycle while the skid entry is empty; the result
// register plus skid entry keep input transfers going while one result waits.
// Reset: synchronous, active low; hunts for a header, no results pending.
module xor_checked_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data,
  output logic [15:0] out_function_code,
  output logic [15:0] out_frame_length,
  output logic [15:0] out_byte_index
);
  import xcfd_pkg::*;

  logic       byte_vld_r, byte_vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       in_take;
  logic       fire;
  logic       skid_full;
  logic       res_vld;
  result_t    res;
  result_t    out_res;

  assign in_stall     = byte_vld_r && skid_full;
  assign in_take      = in_valid && !in_stall;
  assign fire         = byte_vld_r && !skid_full;
  assign byte_vld_nxt = in_take || (byte_vld_r && skid_full);
  assign byte_nxt     = in_take ? in_rx_byte : byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
    end
    byte_r <= byte_nxt;
  end

  xcfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  xcfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_res  (res),
    .full      (skid_full),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_data          = out_res.data;
  assign out_function_code = out_res.function_code;
  assign out_frame_length  = out_res.frame_length;
  assign out_byte_index    = out_res.byte_index;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_valid)
    else $error("skid entry occupied while result register empty");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DATA) |-> (out_byte_index < out_frame_length))
    else $error("payload index beyond declared length");

  a_verdict_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_GOOD || out_kind == KIND_BAD))
      |-> (out_byte_index == 16'd0))
    else $error("frame verdict with nonzero index");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> !res_vld)
    else $error("result produced while output stage full");

endmodule

/* src/xcfd_parser.sv */
// ----------------------------------------------------------------------------
// xcfd_parser
// Frame state machine: header hunt, code/length capture, payload indexing
// and running XOR checksum. One byte per fire.
// ----------------------------------------------------------------------------
module xcfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  output logic              res_vld,
  output xcfd_pkg::result_t res
);
  import xcfd_pkg::*;

  typedef enum logic [6:0] {
    PH_WAIT    = 7'b0000001,
    PH_CODE_HI = 7'b0000010,
    PH_CODE_LO = 7'b0000100,
    PH_LEN_HI  = 7'b0001000,
    PH_LEN_LO  = 7'b0010000,
    PH_DATA    = 7'b0100000,
    PH_CHECK   = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] code_r, code_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  assign cnt_inc  = cnt_r + 16'd1;
  assign len_full = {len_r[15:8], rx_byte};

  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    res_vld   = 1'b0;
    res.kind          = KIND_DATA;
    res.data          = rx_byte;
    res.function_code = code_r;
    res.frame_length  = len_r;
    res.byte_index    = cnt_r;
    if (fire) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rx_byte == HDR_BYTE) begin
            code_nxt  = '0;
            len_nxt   = '0;
            cnt_nxt   = '0;
            xor_nxt   = HDR_BYTE;
            phase_nxt = PH_CODE_HI;
          end
        end
        PH_CODE_HI: begin
          code_nxt  = {rx_byte, 8'h00};
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = PH_CODE_LO;
        end
        PH_CODE_LO: begin
          code_nxt  = {code_r[15:8], rx_byte};
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {rx_byte, 8'h00};
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = len_full;
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = (len_full == 16'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          res_vld = 1'b1;
          xor_nxt = xor_r ^ rx_byte;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_vld        = 1'b1;
          res.kind       = (xor_r == rx_byte) ? KIND_GOOD : KIND_BAD;
          res.byte_index = '0;
          phase_nxt      = PH_WAIT;
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      code_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= HDR_BYTE;
    end else begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

/* src/xcfd_out_stage.sv */
// ----------------------------------------------------------------------------
// xcfd_out_stage
// Result register with a skid entry; takes a result every cycle while the
// skid entry is empty.
// ----------------------------------------------------------------------------
module xcfd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xcfd_pkg::result_t push_res,
  output logic              full,
  output logic              out_vld,
  input  logic              out_stall,
  output xcfd_pkg::result_t out_res
);
  import xcfd_pkg::*;

  logic    main_vld_r, main_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    take;

  assign take    = main_vld_r && !out_stall;
  assign full    = skid_vld_r;
  assign out_vld = main_vld_r;
  assign out_res = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (take) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || take) begin
        main_nxt     = push_res;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_res;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
